[rtl/ksr_pkg.sv]
// Shared constants and controller/datapath command types for the k-group stream reverser.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ksr_pkg;

  localparam int MAX_GROUP = 16;
  localparam int IDX_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int VAL_W     = 32;
  localparam int GS_W      = 5;

  localparam logic [GS_W-1:0] GS_RESET = 5'd4;

  // Controller -> datapath commands.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic [CNT_W-1:0] eff_size;
  } dp_stat_t;

endpackage

[rtl/ksr_if.sv]
// Valid/ready channel interfaces for the input and result streams.
// Depends on ksr_pkg for field widths.
`timescale 1ns / 1ps

interface ksr_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ksr_pkg::VAL_W-1:0] value;
  logic                            list_last;

  modport source (output valid, value, list_last, input ready);
  modport sink   (input valid, value, list_last, output ready);
endinterface

interface ksr_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ksr_pkg::VAL_W-1:0] out_value;
  logic                            run_last;
  logic                            list_end;

  modport source (output valid, out_value, run_last, list_end, input ready);
  modport sink   (input valid, out_value, run_last, list_end, output ready);
endinterface

[rtl/ksr_datapath.sv]
// Datapath: group-size register, 16-entry value store and registered read port.
// Depends on ksr_pkg; driven by ksr_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module ksr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ksr_pkg::GS_W-1:0]          cfg_data,
  input  logic signed [ksr_pkg::VAL_W-1:0]  in_value,
  input  ksr_pkg::dp_cmd_t                  cmd,
  output ksr_pkg::dp_stat_t                 stat,
  output logic signed [ksr_pkg::VAL_W-1:0]  rd_value
);

  logic [ksr_pkg::GS_W-1:0]         group_size_r;
  logic [ksr_pkg::VAL_W-1:0]        store [ksr_pkg::MAX_GROUP];
  logic [ksr_pkg::VAL_W-1:0]        rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= ksr_pkg::GS_RESET;
    end else if (cfg_we) begin
      group_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[cmd.wr_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= store[cmd.rd_addr];
    end
  end

  // Clamp the configured size to 1..MAX_GROUP.
  always_comb begin
    if (group_size_r == '0) begin
      stat.eff_size = ksr_pkg::CNT_W'(1);
    end else if (ksr_pkg::CNT_W'(group_size_r) > ksr_pkg::CNT_W'(ksr_pkg::MAX_GROUP)) begin
      stat.eff_size = ksr_pkg::CNT_W'(ksr_pkg::MAX_GROUP);
    end else begin
      stat.eff_size = ksr_pkg::CNT_W'(group_size_r);
    end
  end

  assign rd_value = rdata_r;

endmodule

[rtl/ksr_ctrl.sv]
// Controller: fill count, group-complete decision and read-out sequencing.
// Depends on ksr_pkg; commands ksr_datapath.
`timescale 1ns / 1ps

module ksr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_list_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_run_last,
  output logic                    out_list_end,
  input  ksr_pkg::dp_stat_t       stat,
  output ksr_pkg::dp_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [ksr_pkg::IDX_W-1:0]    fill_r, fill_nxt;
  logic [ksr_pkg::CNT_W-1:0]    n_r, n_nxt;
  logic [ksr_pkg::CNT_W-1:0]    k_r, k_nxt;
  logic                         rev_r, rev_nxt;
  logic                         last_r, last_nxt;
  logic [ksr_pkg::CNT_W-1:0]    n_new;
  logic [ksr_pkg::CNT_W-1:0]    k_inc;
  logic [ksr_pkg::CNT_W-1:0]    rev_idx;
  logic                         final_item;

  assign n_new      = ksr_pkg::CNT_W'(fill_r) + ksr_pkg::CNT_W'(1);
  assign k_inc      = k_r + ksr_pkg::CNT_W'(1);
  assign rev_idx    = n_r - k_inc;
  assign final_item = (k_inc == n_r);

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_run_last = final_item;
  assign out_list_end = final_item && last_r;

  always_comb begin
    cmd.wr_en   = in_valid && in_ready;
    cmd.wr_addr = fill_r;
    cmd.rd_en   = (state_r == S_RD);
    cmd.rd_addr = rev_r ? rev_idx[ksr_pkg::IDX_W-1:0] : k_r[ksr_pkg::IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    rev_nxt   = rev_r;
    last_nxt  = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_list_last;
          n_nxt    = n_new;
          k_nxt    = '0;
          if (n_new >= stat.eff_size) begin
            rev_nxt   = 1'b1;
            fill_nxt  = '0;
            state_nxt = S_RD;
          end else if (in_list_last) begin
            rev_nxt   = 1'b0;
            fill_nxt  = '0;
            state_nxt = S_RD;
          end else begin
            fill_nxt = n_new[ksr_pkg::IDX_W-1:0];
          end
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (final_item) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      n_r     <= '0;
      k_r     <= '0;
      rev_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      rev_r   <= rev_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

[rtl/k_group_stream_reverser_top.sv]
// k-group stream reverser: usage notes.
// in_s carries one list value per transaction with list_last on the final
// element. out_s carries the reordered values with run_last on the last
// result of a run and list_end on the final element of the list.
// cfg_we/cfg_data set the group size (0 acts as 1, above 16 acts as 16);
// write it only while the block is idle. Reset sets it to 4.
// Values collect in a 16-entry store. When a group fills, it is read back
// in reverse order; a partial group closed by list_last reads back in order.
// Sequencing: an input that causes no result is taken and the block stays idle.
// An input that closes a group ties up the block while its results go out:
// each result is first read from the store and then presented from the output
// register. in_s.ready is low until the last result is taken.
// A stalled receiver holds the current result in the output register; no
// further reads happen until it is taken.
// Synchronous active-low reset empties the fill count and returns to idle;
// store contents are not cleared and are only read after being written.
// Depends on ksr_pkg, ksr_if, ksr_ctrl and ksr_datapath.
`timescale 1ns / 1ps

module k_group_stream_reverser_top (
  input  logic                     clk,
  input  logic                     rst_n,
  ksr_in_if.sink                   in_s,
  ksr_out_if.source                out_s,
  input  logic                     cfg_we,
  input  logic [ksr_pkg::GS_W-1:0] cfg_data
);

  ksr_pkg::dp_cmd_t                 cmd;
  ksr_pkg::dp_stat_t                stat;
  logic                             in_ready;
  logic                             out_valid;
  logic                             run_last;
  logic                             list_end;
  logic signed [ksr_pkg::VAL_W-1:0] rd_value;

  ksr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_s.valid),
    .in_list_last (in_s.list_last),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_s.ready),
    .out_run_last (run_last),
    .out_list_end (list_end),
    .stat         (stat),
    .cmd          (cmd)
  );

  ksr_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_value (in_s.value),
    .cmd      (cmd),
    .stat     (stat),
    .rd_value (rd_value)
  );

  assign in_s.ready      = in_ready;
  assign out_s.valid     = out_valid;
  assign out_s.out_value = rd_value;
  assign out_s.run_last  = run_last;
  assign out_s.list_end  = list_end;

endmodule

[verif/k_group_stream_reverser_top_tb.sv]
// Self-checking testbench for k_group_stream_reverser_top: a directed table, then random lists
// with random group sizes, checked transaction by transaction against an in-bench predictor.
// Depends on ksr_pkg, ksr_if and the reverser RTL.
`timescale 1ns / 1ps

module k_group_stream_reverser_top_tb;

  localparam int RANDOM_ITEMS  = 126;
  localparam int SETTLE_CYCLES = 4;    // settle time after the expected results are drained
  localparam int TAIL_CYCLES   = 40;   // idle time after the final drain
  localparam int QUIET_LIMIT   = 2000;
  localparam int PRINT_CAP     = 20;

  typedef struct packed {
    logic signed [ksr_pkg::VAL_W-1:0] value;
    logic                             run_last;
    logic                             list_end;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [ksr_pkg::VAL_W-1:0] value;      // list value, or group size for ROW_SIZE
    logic                      list_last;
    bit                        typed;      // want holds the expected result
    result_t                   want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [ksr_pkg::GS_W-1:0] cfg_data;

  ksr_in_if  in_ch();
  ksr_out_if out_ch();

  k_group_stream_reverser_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_ch),
    .out_s   (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block: open group, fill level and group size register.
  logic [ksr_pkg::VAL_W-1:0] group_vals [ksr_pkg::MAX_GROUP];
  int unsigned               held_count;
  logic [ksr_pkg::GS_W-1:0]  size_setting;

  result_t     fresh_results[$];
  result_t     pending_results[$];
  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned results_seen    = 0;
  int unsigned size_writes     = 0;
  int unsigned groups_reversed = 0;
  int unsigned tails_in_order  = 0;
  int unsigned quiet_cycles    = 0;
  bit          calm            = 1'b0;

  function automatic void absorb_value(input logic [ksr_pkg::VAL_W-1:0] v, input logic last);
    int unsigned size_now;
    int unsigned n;
    bit          flip;
    result_t     r;
    fresh_results.delete();
    size_now = (size_setting == 0) ? 1 :
               (size_setting > ksr_pkg::MAX_GROUP) ? ksr_pkg::MAX_GROUP : int'(size_setting);
    if (held_count < ksr_pkg::MAX_GROUP) begin
      group_vals[held_count] = v;
      held_count++;
    end
    // a lowered size closes the group as soon as the fill level reaches or passes it
    if (held_count >= size_now) flip = 1'b1;
    else if (last) flip = 1'b0;
    else return;
    n = held_count;
    for (int unsigned k = 0; k < n; k++) begin
      r.value    = group_vals[flip ? n - 1 - k : k];
      r.run_last = (k + 1 == n);
      r.list_end = (k + 1 == n) && last;
      fresh_results.push_back(r);
    end
    if (flip) groups_reversed++;
    else tails_in_order++;
    held_count = 0;
  endfunction

  function automatic stim_row_t item_row(input logic [ksr_pkg::VAL_W-1:0] v, input logic last);
    return '{kind: ROW_ITEM, value: v, list_last: last, typed: 1'b0, want: '0};
  endfunction

  // Only valid at an effective group size of 1 (setting 0 or 1): the value comes straight back as a run of one.
  function automatic stim_row_t pass_row(input logic [ksr_pkg::VAL_W-1:0] v, input logic last);
    return '{kind: ROW_ITEM, value: v, list_last: last, typed: 1'b1,
             want: '{value: v, run_last: 1'b1, list_end: last}};
  endfunction

  function automatic stim_row_t size_row(input logic [ksr_pkg::GS_W-1:0] new_size);
    return '{kind: ROW_SIZE, value: ksr_pkg::VAL_W'(new_size), list_last: 1'b0, typed: 1'b0,
             want: '0};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic drain_results();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [ksr_pkg::GS_W-1:0] new_size);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= new_size;
    @(posedge clk);
    cfg_we       <= 1'b0;
    size_setting = new_size;
    size_writes++;
  endtask

  task automatic send_item(input logic [ksr_pkg::VAL_W-1:0] v, input logic last,
                           input bit typed, input result_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      if (in_ch.valid) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.list_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_value(v, last);
    if (typed) pending_results.push_back(want);
    else foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
    items_sent++;
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // stretches with no idling on either side
  always @(posedge clk) if ($urandom_range(0, 199) == 0) calm <= !calm;

  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_ch.out_value));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.out_value !== want.value)
          report_mismatch($sformatf("out_value %h, want %h", out_ch.out_value, want.value));
        if (out_ch.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b on value %h",
                                    out_ch.run_last, want.run_last, want.value));
        if (out_ch.list_end !== want.list_end)
          report_mismatch($sformatf("list_end %b, want %b on value %h",
                                    out_ch.list_end, want.list_end, want.value));
      end
    end
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no transaction for %0d cycles", QUIET_LIMIT);
    $display("[k_group_stream_reverser_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                 stim_rows[$];
    int unsigned               random_sent;
    int unsigned               burst;
    logic [ksr_pkg::GS_W-1:0]  next_size;
    logic [ksr_pkg::VAL_W-1:0] next_value;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.list_last <= 1'b0;
    held_count   = 0;
    size_setting = ksr_pkg::GS_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset size 4: short list closed early, so it comes back in order
    stim_rows = '{item_row(32'h8000_0000, 1'b0), item_row(32'h7FFF_FFFF, 1'b0),
                  item_row(32'hFFFF_FFFF, 1'b1),
                  size_row(5'd0), pass_row(32'hFFFF_FFFF, 1'b0), pass_row(32'h0000_0000, 1'b1),
                  size_row(5'd31)};
    // saturated size: one full 16-value group that also ends the list
    for (int k = 0; k < ksr_pkg::MAX_GROUP; k++)
      stim_rows.push_back(item_row({16'hA5C3, 8'(k), 8'(ksr_pkg::MAX_GROUP - k)},
                                   k == ksr_pkg::MAX_GROUP - 1));
    // size lowered with two values held: the third closes a reversed group of three
    stim_rows.push_back(size_row(5'd16));
    stim_rows.push_back(item_row(32'h0000_0001, 1'b0));
    stim_rows.push_back(item_row(32'h0000_0002, 1'b0));
    stim_rows.push_back(size_row(5'd1));
    stim_rows.push_back(item_row(32'h0000_0003, 1'b0));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_SIZE) begin
        write_size(stim_rows[i].value[ksr_pkg::GS_W-1:0]);
      end else begin
        send_item(stim_rows[i].value, stim_rows[i].list_last, stim_rows[i].typed,
                  stim_rows[i].want);
      end
    end

    // Random lists; a size change often lands on a partly filled group.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       next_size = 5'd0;
        1:       next_size = 5'd1;
        2:       next_size = 5'd16;
        3:       next_size = ksr_pkg::GS_W'($urandom_range(17, 31));
        4:       next_size = ksr_pkg::GS_W'($urandom_range(7, 15));
        default: next_size = ksr_pkg::GS_W'($urandom_range(2, 6));
      endcase
      write_size(next_size);
      burst = $urandom_range(3, 30);
      if (burst > RANDOM_ITEMS - random_sent) burst = RANDOM_ITEMS - random_sent;
      repeat (burst) begin
        case ($urandom_range(0, 15))
          0:       next_value = 32'h8000_0000;
          1:       next_value = 32'h7FFF_FFFF;
          2:       next_value = 32'h0000_0000;
          3:       next_value = 32'hFFFF_FFFF;
          default: next_value = $urandom;
        endcase
        send_item(next_value, $urandom_range(0, 6) == 0, 1'b0, '0);
        random_sent++;
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d list values under %0d group size writes, sizes 0 through 31.",
             items_sent, size_writes);
    $display("Checked %0d results: %0d reversed groups, %0d in-order tails.",
             results_seen, groups_reversed, tails_in_order);
    if (mismatches == 0) begin
      $display("[k_group_stream_reverser_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[k_group_stream_reverser_top] ERROR");
    end
    $finish;
  end

endmodule
